[hdl/gbe_pkg.sv]
// gap buffer engine package: command codes, status codes and register map
// depends on nothing; imported by the gap buffer engine top level
package gbe_pkg;

    // command codes
    localparam logic [2:0] CMD_INSERT   = 3'd0;
    localparam logic [2:0] CMD_DELETE   = 3'd1;
    localparam logic [2:0] CMD_LEFT     = 3'd2;
    localparam logic [2:0] CMD_RIGHT    = 3'd3;
    localparam logic [2:0] CMD_MOVE_BY  = 3'd4;
    localparam logic [2:0] CMD_MOVE_TO  = 3'd5;

    // status codes
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    // register map: word index taken from paddr[2]
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_FIRST_ELEMENT = 1'b0;

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int FIELD_W  = 8;
    localparam int AMOUNT_W = 9;

    typedef logic [FIELD_W-1:0] field_t;

endpackage

[hdl/gbe_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies; used for the element store of the gap buffer engine
module gbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[hdl/gap_buffer_engine.sv]
// gap buffer engine top level: command sequencer, gap pointers and apb register
// depends on gbe_pkg and gbe_ram (element store)
//
// A fixed-size gap buffer of CAPACITY slots (up to CAPACITY - 1 elements) with
// the cursor just before the gap; slot zero always reads as the first_element
// register. Each command word yields one response word. The element store is a
// single ram with one write and one registered read port, and a small sequencer
// drives it. Insert, delete and refused commands pass the decode, read-cursor and
// response states; steps and moves add a ram read state and a ram write state
// for each position moved, the moves after a clamp state. The command side is
// stalled throughout; a finished response sits in an output register so the next
// command can be taken while it waits. There is no clearing pass after reset:
// slots are only read after they are written.
module gap_buffer_engine
    import gbe_pkg::*;
#(
    parameter int CAPACITY      = 256,
    parameter int ELEMENT_WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  logic [CMD_W-1:0]      command,
    input  logic [FIELD_W-1:0]    data_value,
    input  logic signed [AMOUNT_W-1:0] move_amount,
    input  logic [FIELD_W-1:0]    target_index,
    // response channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic                  status,
    output logic [FIELD_W-1:0]    cursor_index,
    output logic [FIELD_W-1:0]    content_length,
    output logic [FIELD_W-1:0]    cursor_value,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int SW = ((AW > AMOUNT_W) ? AW : AMOUNT_W) + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [AW-1:0] ONE       = AW'(1);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_CLAMP    = 3'd2;
    localparam logic [2:0] S_STEP_RD  = 3'd3;
    localparam logic [2:0] S_STEP_WR  = 3'd4;
    localparam logic [2:0] S_READ_CUR = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0]               state_reg, state_next;
    logic [AW-1:0]            gap_first_reg, gap_first_next;
    logic [AW-1:0]            gap_last_reg, gap_last_next;
    logic [AW-1:0]            moves_remaining_reg, moves_remaining_next;
    logic                     dir_left_reg, dir_left_next;
    logic                     status_reg, status_next;
    logic signed [SW-1:0]     delta_reg, delta_next;
    logic [CMD_W-1:0]         command_reg;
    logic [FIELD_W-1:0]       data_reg;
    logic signed [AMOUNT_W-1:0] amount_reg;
    logic [FIELD_W-1:0]       target_reg;
    logic [FIELD_W-1:0]       first_element_reg;

    logic                     rsp_valid_reg, rsp_valid_next;
    logic                     rsp_status_reg;
    logic [FIELD_W-1:0]       rsp_cursor_reg;
    logic [FIELD_W-1:0]       rsp_length_reg;
    logic [FIELD_W-1:0]       rsp_value_reg;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [ELEMENT_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [ELEMENT_WIDTH-1:0] ram_rdata;

    logic                     cmd_accept;
    logic                     rsp_load;
    logic                     cfg_write;
    logic [AW-1:0]            cursor;
    logic [AW-1:0]            length;
    logic [AW-1:0]            avail;
    logic [SW-1:0]            magnitude;
    logic [SW-1:0]            target_clamped;

    // element store
    gbe_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshakes
    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign rsp_load   = (state_reg == S_RESP) && (!rsp_valid_reg || !rsp_stall);

    // cursor and length from the gap pointers
    assign cursor = gap_first_reg - ONE;
    assign length = gap_first_reg + LAST_SLOT - gap_last_reg;

    // clamp helpers for the move commands
    assign target_clamped = (SW'(target_reg) > SW'(length)) ? SW'(length) : SW'(target_reg);
    assign magnitude = delta_reg[SW-1] ? SW'(-delta_reg) : SW'(delta_reg);
    assign avail     = delta_reg[SW-1] ? cursor : (LAST_SLOT - gap_last_reg);

    // sequencer
    always_comb
    begin
        state_next           = state_reg;
        gap_first_next       = gap_first_reg;
        gap_last_next        = gap_last_reg;
        moves_remaining_next = moves_remaining_reg;
        dir_left_next        = dir_left_reg;
        status_next          = status_reg;
        delta_next           = delta_reg;
        ram_we               = 1'b0;
        ram_waddr            = gap_first_reg;
        ram_wdata            = ELEMENT_WIDTH'(data_reg);
        ram_raddr            = cursor;
        rsp_valid_next       = rsp_valid_reg && rsp_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    status_next = STATUS_DONE;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_READ_CUR;
                case (command_reg)
                    CMD_INSERT:
                    begin
                        if (gap_first_reg == gap_last_reg)
                        begin
                            status_next = STATUS_REFUSED;
                        end
                        else
                        begin
                            ram_we         = 1'b1;
                            gap_first_next = gap_first_reg + ONE;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (gap_first_reg == ONE)
                        begin
                            status_next = STATUS_REFUSED;
                        end
                        else
                        begin
                            gap_first_next = cursor;
                        end
                    end
                    CMD_LEFT:
                    begin
                        if (gap_first_reg == ONE)
                        begin
                            status_next = STATUS_REFUSED;
                        end
                        else
                        begin
                            moves_remaining_next = ONE;
                            dir_left_next        = 1'b1;
                            state_next           = S_STEP_RD;
                        end
                    end
                    CMD_RIGHT:
                    begin
                        if (gap_last_reg == LAST_SLOT)
                        begin
                            status_next = STATUS_REFUSED;
                        end
                        else
                        begin
                            moves_remaining_next = ONE;
                            dir_left_next        = 1'b0;
                            state_next           = S_STEP_RD;
                        end
                    end
                    CMD_MOVE_BY:
                    begin
                        delta_next = SW'(amount_reg);
                        state_next = S_CLAMP;
                    end
                    CMD_MOVE_TO:
                    begin
                        delta_next = signed'(target_clamped - SW'(cursor));
                        state_next = S_CLAMP;
                    end
                    default:
                    begin
                        status_next = STATUS_REFUSED;
                    end
                endcase
            end
            S_CLAMP:
            begin
                // limit the move to the elements available on that side
                dir_left_next = delta_reg[SW-1];
                if (magnitude > SW'(avail))
                begin
                    moves_remaining_next = avail;
                end
                else
                begin
                    moves_remaining_next = AW'(magnitude);
                end
                if ((magnitude == '0) || (avail == '0))
                begin
                    state_next = S_READ_CUR;
                end
                else
                begin
                    state_next = S_STEP_RD;
                end
            end
            S_STEP_RD:
            begin
                // fetch the element that crosses the gap
                ram_raddr  = dir_left_reg ? cursor : (gap_last_reg + ONE);
                state_next = S_STEP_WR;
            end
            S_STEP_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (dir_left_reg)
                begin
                    ram_waddr      = gap_last_reg;
                    gap_first_next = gap_first_reg - ONE;
                    gap_last_next  = gap_last_reg - ONE;
                end
                else
                begin
                    ram_waddr      = gap_first_reg;
                    gap_first_next = gap_first_reg + ONE;
                    gap_last_next  = gap_last_reg + ONE;
                end
                moves_remaining_next = moves_remaining_reg - ONE;
                if (moves_remaining_reg == ONE)
                begin
                    state_next = S_READ_CUR;
                end
                else
                begin
                    state_next = S_STEP_RD;
                end
            end
            S_READ_CUR:
            begin
                ram_raddr  = cursor;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            gap_first_reg       <= ONE;
            gap_last_reg        <= LAST_SLOT;
            moves_remaining_reg <= '0;
            dir_left_reg        <= 1'b0;
            status_reg          <= STATUS_DONE;
            delta_reg           <= '0;
            rsp_valid_reg       <= 1'b0;
            first_element_reg   <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            gap_first_reg       <= gap_first_next;
            gap_last_reg        <= gap_last_next;
            moves_remaining_reg <= moves_remaining_next;
            dir_left_reg        <= dir_left_next;
            status_reg          <= status_next;
            delta_reg           <= delta_next;
            rsp_valid_reg       <= rsp_valid_next;
            if (cfg_write)
            begin
                first_element_reg <= pwdata[FIELD_W-1:0];
            end
        end
    end

    // command word capture
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            command_reg <= command;
            data_reg    <= data_value;
            amount_reg  <= move_amount;
            target_reg  <= target_index;
        end
    end

    // response word register
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_status_reg <= status_reg;
            rsp_cursor_reg <= FIELD_W'(cursor);
            rsp_length_reg <= FIELD_W'(length);
            rsp_value_reg  <= (gap_first_reg == ONE) ? first_element_reg
                                                     : FIELD_W'(ram_rdata);
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_status_reg;
    assign cursor_index   = rsp_cursor_reg;
    assign content_length = rsp_length_reg;
    assign cursor_value   = rsp_value_reg;

    // apb register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_FIRST_ELEMENT);
    assign prdata    = (paddr[2] == REG_FIRST_ELEMENT) ? {24'd0, first_element_reg} : 32'd0;

    // gap never closes past its last slot
    a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
        gap_first_reg <= gap_last_reg)
        else $error("gap pointers crossed");

    // slot zero stays with the sentinel
    a_sentinel_kept: assert property (@(posedge clk) disable iff (!rst_n)
        gap_first_reg != '0)
        else $error("cursor moved past the sentinel");

    // element transfers only run with moves left to do
    a_moves_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP_RD || state_reg == S_STEP_WR) |-> moves_remaining_reg != '0)
        else $error("element transfer with no moves remaining");

    // a response only appears from the response state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("response raised outside the response state");

endmodule
